// ----- hdl/gwr_pkg.sv -----
package gwr_pkg;

  // Field and datapath widths
  localparam int ANG_W      = 16;
  localparam int COORD_W    = 16;
  localparam int TRIG_W     = 16;
  localparam int COL_W      = 6;
  localparam int TYPE_W     = 2;
  localparam int HIT_W      = 18;
  localparam int DIST_W     = 16;
  localparam int HGT_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int STEP_W     = 12;
  localparam int OFF_W      = 6;

  // Cast position accumulators, wide enough for the full crossing walk
  localparam int POS_W      = 36;

  // Shared divider and root unit widths
  localparam int DIV_NUM_W  = 28;
  localparam int DIV_DEN_W  = 16;
  localparam int SQ_IN_W    = 34;
  localparam int SQ_OUT_W   = 17;
  localparam int SQ_REM_W   = 19;

  // CORDIC
  localparam int CORDIC_W        = 25;
  localparam int CORDIC_ITERS    = 16;
  localparam int CORDIC_GAIN_Q20 = 636751;
  localparam int ONE_Q14         = 16384;

  // Grid and screen constants (Q.7 positions, 64-pixel tiles)
  localparam int TILE_SHIFT  = 13;
  localparam int TILE_Q      = 8192;
  localparam int HEIGHT_NUM  = 655360;
  localparam int HEIGHT_MAX  = 4095;
  localparam int SCREEN_MID  = 240;
  localparam int DIST_MAX    = 65535;

  // Binary angle landmarks
  localparam logic [ANG_W-1:0] ANG_ZERO    = 16'd0;
  localparam logic [ANG_W-1:0] ANG_QUARTER = 16'd16384;
  localparam logic [ANG_W-1:0] ANG_HALF    = 16'd32768;
  localparam logic [ANG_W-1:0] ANG_3QUART  = 16'd49152;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_LO    = 2'd0,
    CFG_MAP_HI    = 2'd1,
    CFG_RAY_STEP  = 2'd2,
    CFG_START_OFF = 2'd3
  } cfg_idx_t;

  // Rotation angles of the CORDIC stages, 2^22 units per quarter turn
  function automatic logic [22:0] atan_unit(input logic [3:0] i);
    logic [22:0] r;
    case (i)
      4'd0:    r = 23'd2097152;
      4'd1:    r = 23'd1238021;
      4'd2:    r = 23'd654136;
      4'd3:    r = 23'd332050;
      4'd4:    r = 23'd166669;
      4'd5:    r = 23'd83416;
      4'd6:    r = 23'd41718;
      4'd7:    r = 23'd20860;
      4'd8:    r = 23'd10430;
      4'd9:    r = 23'd5215;
      4'd10:   r = 23'd2608;
      4'd11:   r = 23'd1304;
      4'd12:   r = 23'd652;
      4'd13:   r = 23'd326;
      4'd14:   r = 23'd163;
      default: r = 23'd81;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/gwr_cordic.sv -----
module gwr_cordic
  import gwr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ANG_W-1:0]         angle,
  output logic                     done,
  output logic signed [TRIG_W-1:0] cos_q,
  output logic signed [TRIG_W-1:0] sin_q
);

  logic signed [CORDIC_W-1:0] x_r, y_r, z_r;
  logic [1:0]                 quad_r;
  logic [3:0]                 it_r;
  logic                       busy_r, done_r;
  logic signed [CORDIC_W-1:0] xs, ys, atan_s;
  logic signed [TRIG_W-1:0]   cm, sm;

  // Round to Q1.14 and clamp to [0, 1]
  function automatic logic [TRIG_W-2:0] clamp_unit(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    logic [TRIG_W-2:0]          o;
    r = (v + CORDIC_W'(32)) >>> 6;
    if (r < 0) o = '0;
    else if (r > CORDIC_W'(ONE_Q14)) o = (TRIG_W-1)'(ONE_Q14);
    else o = r[TRIG_W-2:0];
    return o;
  endfunction

  assign xs     = x_r >>> it_r;
  assign ys     = y_r >>> it_r;
  assign atan_s = $signed({2'b00, atan_unit(it_r)});

  // One rotation per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
        x_r    <= CORDIC_W'(CORDIC_GAIN_Q20);
        y_r    <= '0;
        z_r    <= $signed({3'b000, angle[13:0], 8'h00});
        quad_r <= angle[15:14];
      end else if (busy_r) begin
        if (!z_r[CORDIC_W-1]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_s;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_s;
        end
        if (it_r == 4'(CORDIC_ITERS-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          it_r <= it_r + 4'd1;
        end
      end
    end
  end

  // Quadrant fold of the first-quadrant result
  always_comb begin
    cm = $signed({1'b0, clamp_unit(x_r)});
    sm = $signed({1'b0, clamp_unit(y_r)});
    case (quad_r)
      2'd0: begin cos_q = cm;  sin_q = sm;  end
      2'd1: begin cos_q = -sm; sin_q = cm;  end
      2'd2: begin cos_q = -cm; sin_q = -sm; end
      default: begin cos_q = sm; sin_q = -cm; end
    endcase
  end

  assign done = done_r;

endmodule

// ----- hdl/gwr_divider.sv -----
module gwr_divider
  import gwr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_NUM_W-1:0] q_r;
  logic [DIV_DEN_W-1:0] rem_r, den_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r, done_r;
  logic [DIV_DEN_W:0]   rem_sh, diff;
  logic                 fits;

  assign rem_sh = {rem_r, q_r[DIV_NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign fits   = rem_sh >= {1'b0, den_r};

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_NUM_W-1);
        q_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        q_r   <= {q_r[DIV_NUM_W-2:0], fits};
        rem_r <= fits ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ----- hdl/gwr_isqrt.sv -----
module gwr_isqrt
  import gwr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SQ_IN_W-1:0]  value,
  output logic                done,
  output logic [SQ_OUT_W-1:0] root
);

  localparam int CNT_W = $clog2(SQ_OUT_W);

  logic [SQ_IN_W-1:0]  val_r;
  logic [SQ_REM_W-1:0] rem_r;
  logic [SQ_OUT_W-1:0] root_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r, done_r;
  logic [SQ_REM_W-1:0] rem_in, trial;
  logic                fits;

  assign rem_in = {rem_r[SQ_REM_W-3:0], val_r[SQ_IN_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = rem_in >= trial;

  // Digit-by-digit floor root, one result bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SQ_OUT_W-1);
        val_r  <= value;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        val_r  <= {val_r[SQ_IN_W-3:0], 2'b00};
        rem_r  <= fits ? rem_in - trial : rem_in;
        root_r <= {root_r[SQ_OUT_W-2:0], fits};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- hdl/grid_wall_raycaster_core.sv -----
// The work of each ray is set by the shared units, and a ray also waits out any output
// stall: up to two 16-step CORDIC passes (ray angle and fisheye correction), up to five
// 28-step divisions and up to two 17-step roots.
// in_ready is low for the whole frame of RAY_COUNT rays. Reset (rst_n low, synchronous)
// returns to idle, drops out_valid and loads the register defaults (empty map, step 182,
// offset 30).
module grid_wall_raycaster_core
  import gwr_pkg::*;
#(
  parameter int RAY_COUNT     = 60,
  parameter int MAX_CROSSINGS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_W-1:0]      in_viewer_x,
  input  logic [COORD_W-1:0]      in_viewer_y,
  input  logic [ANG_W-1:0]        in_view_angle,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COL_W-1:0]        out_column,
  output logic [TYPE_W-1:0]       out_wall_type,
  output logic                    out_vertical_side,
  output logic signed [HIT_W-1:0] out_hit_x,
  output logic signed [HIT_W-1:0] out_hit_y,
  output logic [DIST_W-1:0]       out_wall_distance,
  output logic [HGT_W-1:0]        out_slice_height,
  output logic signed [HGT_W-1:0] out_slice_top,
  output logic                    out_last_ray,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int CNT_W = (MAX_CROSSINGS > 1) ? $clog2(MAX_CROSSINGS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIG, S_SETUP, S_OFF, S_STEP, S_CAST, S_SQX, S_SQY, S_SQRT,
    S_PICK, S_FISH, S_SAT, S_HGT, S_HDIV, S_EMIT
  } state_t;

  // Configuration
  logic [2*CFG_DATA_W-1:0] map_r;
  logic [STEP_W-1:0]       ray_step_r;
  logic [OFF_W-1:0]        start_off_r;

  // Sequencer and ray state
  state_t                     state_r;
  logic [COORD_W-1:0]         px_r, py_r;
  logic [ANG_W-1:0]           view_r, ra_r;
  logic [COL_W-1:0]           k_r;
  logic signed [TRIG_W-1:0]   c_r, s_r;
  logic                       dir_r, neg_r, along_inc_r;
  logic signed [HIT_W-1:0]    line0_r;
  logic [TRIG_W-2:0]          trig_mag_r;
  logic signed [POS_W-1:0]    cross0_r, cx_r, cy_r, stx_r, sty_r;
  logic [CNT_W-1:0]           n_r;
  logic                       hh_r, hv_r;
  logic [TYPE_W-1:0]          th_r, tv_r, type_r;
  logic [COORD_W-1:0]         hx_r, hy_r, vx_r, vy_r, rx_r, ry_r;
  logic [SQ_OUT_W-1:0]        dh_r, dv_r, dist_r;
  logic [31:0]                prod_r;
  logic signed [33:0]         corr_r;
  logic [DIST_W-1:0]          dist16_r;
  logic [HGT_W-1:0]           height_r;
  logic                       side_r;

  // Unit requests
  logic                 cord_start_r, div_start_r, sq_start_r;
  logic [ANG_W-1:0]     cord_ang_r;
  logic [DIV_NUM_W-1:0] div_num_r;
  logic [DIV_DEN_W-1:0] div_den_r;
  logic [SQ_IN_W-1:0]   sq_in_r;
  logic                 cord_done, div_done, sq_done;
  logic signed [TRIG_W-1:0] cord_cos, cord_sin;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [SQ_OUT_W-1:0]  sq_root;

  // Result register
  logic                    out_valid_r, o_side_r, o_last_r;
  logic [COL_W-1:0]        o_col_r;
  logic [TYPE_W-1:0]       o_type_r;
  logic [COORD_W-1:0]      o_hx_r, o_hy_r;
  logic [DIST_W-1:0]       o_dist_r;
  logic [HGT_W-1:0]        o_hgt_r, o_top_r;

  // Datapath helpers
  logic [COORD_W-1:0]       gx, gy, grid_base, along_p, other_p, sel_x, sel_y;
  logic                     h_ok, v_ok, fwd_h, left_v, along_inc, dir_ok, hit_sel;
  logic signed [HIT_W-1:0]  line0, ad_full;
  logic [13:0]              ad;
  logic signed [TRIG_W-1:0] trig_num, trig_den_s;
  logic [TRIG_W-2:0]        trig_mag;
  logic [DIV_DEN_W-1:0]     trig_den;
  logic [28:0]              prod_mag;
  logic signed [POS_W-1:0]  quo_ext, quo_s, along_step;
  logic                     in_map, vert, last_cross;
  logic [5:0]               cell_idx;
  logic [TYPE_W-1:0]        cell_val;
  logic signed [16:0]       dx, dy;
  logic signed [33:0]       dxx, dyy;
  logic [ANG_W-1:0]         first_ang;

  assign first_ang = in_view_angle - ANG_W'(start_off_r * ray_step_r);

  // Grid line setup for the current cast direction
  always_comb begin
    gx         = {px_r[COORD_W-1:TILE_SHIFT], {TILE_SHIFT{1'b0}}};
    gy         = {py_r[COORD_W-1:TILE_SHIFT], {TILE_SHIFT{1'b0}}};
    h_ok       = (ra_r != ANG_ZERO) && (ra_r != ANG_HALF) && (s_r != '0);
    v_ok       = (ra_r != ANG_QUARTER) && (ra_r != ANG_3QUART) && (c_r != '0);
    fwd_h      = ra_r < ANG_HALF;
    left_v     = (ra_r > ANG_QUARTER) && (ra_r < ANG_3QUART);
    dir_ok     = dir_r ? v_ok : h_ok;
    along_inc  = dir_r ? !left_v : fwd_h;
    grid_base  = dir_r ? gx : gy;
    along_p    = dir_r ? px_r : py_r;
    other_p    = dir_r ? py_r : px_r;
    line0      = along_inc ? $signed({2'b00, grid_base}) + HIT_W'(TILE_Q)
                           : $signed({2'b00, grid_base}) - HIT_W'(1);
    ad_full    = line0 - $signed({2'b00, along_p});
    ad         = ad_full[HIT_W-1] ? 14'(-ad_full) : ad_full[13:0];
    trig_num   = dir_r ? s_r : c_r;
    trig_den_s = dir_r ? c_r : s_r;
    trig_mag   = trig_num[TRIG_W-1] ? (TRIG_W-1)'(-trig_num) : trig_num[TRIG_W-2:0];
    trig_den   = trig_den_s[TRIG_W-1] ? DIV_DEN_W'(-trig_den_s) : DIV_DEN_W'(trig_den_s);
    prod_mag   = ad * trig_mag;
    quo_ext    = $signed({{(POS_W-DIV_NUM_W){1'b0}}, div_quo});
    quo_s      = neg_r ? -quo_ext : quo_ext;
    along_step = along_inc_r ? POS_W'(TILE_Q) : -POS_W'(TILE_Q);
  end

  // Cell test at the current crossing
  always_comb begin
    in_map     = (cx_r[POS_W-1:COORD_W] == '0) && (cy_r[POS_W-1:COORD_W] == '0);
    cell_idx   = {cy_r[COORD_W-1:TILE_SHIFT], cx_r[COORD_W-1:TILE_SHIFT]};
    cell_val   = map_r[{cell_idx, 1'b0} +: TYPE_W];
    last_cross = n_r == CNT_W'(MAX_CROSSINGS-1);
  end

  // Squared distance operands and hit selection
  always_comb begin
    hit_sel = dir_r ? hv_r : hh_r;
    sel_x   = dir_r ? vx_r : hx_r;
    sel_y   = dir_r ? vy_r : hy_r;
    dx      = $signed({1'b0, sel_x}) - $signed({1'b0, px_r});
    dy      = $signed({1'b0, sel_y}) - $signed({1'b0, py_r});
    dxx     = dx * dx;
    dyy     = dy * dy;
    vert    = hv_r && (!hh_r || (dv_r < dh_r));
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r       <= '0;
      ray_step_r  <= STEP_W'(182);
      start_off_r <= OFF_W'(30);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAP_LO:    map_r[CFG_DATA_W-1:0]            <= cfg_data;
        CFG_MAP_HI:    map_r[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_data;
        CFG_RAY_STEP:  ray_step_r  <= cfg_data[STEP_W-1:0];
        CFG_START_OFF: start_off_r <= cfg_data[OFF_W-1:0];
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      cord_start_r <= 1'b0;
      div_start_r  <= 1'b0;
      sq_start_r   <= 1'b0;
      dir_r        <= 1'b0;
      k_r          <= '0;
      n_r          <= '0;
      hh_r         <= 1'b0;
      hv_r         <= 1'b0;
    end else begin
      cord_start_r <= 1'b0;
      div_start_r  <= 1'b0;
      sq_start_r   <= 1'b0;
      // Result beat taken; the emit state reloads it itself
      if (out_valid_r && out_ready && (state_r != S_EMIT)) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            px_r         <= in_viewer_x;
            py_r         <= in_viewer_y;
            view_r       <= in_view_angle;
            ra_r         <= first_ang;
            k_r          <= '0;
            cord_ang_r   <= first_ang;
            cord_start_r <= 1'b1;
            state_r      <= S_TRIG;
          end
        end

        S_TRIG: begin
          if (cord_done) begin
            c_r     <= cord_cos;
            s_r     <= cord_sin;
            hh_r    <= 1'b0;
            hv_r    <= 1'b0;
            th_r    <= '0;
            tv_r    <= '0;
            hx_r    <= px_r;
            hy_r    <= py_r;
            vx_r    <= px_r;
            vy_r    <= py_r;
            dh_r    <= '0;
            dv_r    <= '0;
            dir_r   <= 1'b0;
            state_r <= S_SETUP;
          end
        end

        // First crossing offset: |line - p| * trig / |other trig|
        S_SETUP: begin
          if (dir_ok) begin
            line0_r     <= line0;
            neg_r       <= trig_num[TRIG_W-1];
            along_inc_r <= along_inc;
            trig_mag_r  <= trig_mag;
            div_num_r   <= prod_mag[DIV_NUM_W-1:0];
            div_den_r   <= trig_den;
            div_start_r <= 1'b1;
            state_r     <= S_OFF;
          end else if (!dir_r) begin
            dir_r <= 1'b1;
          end else begin
            dir_r   <= 1'b0;
            state_r <= S_SQX;
          end
        end

        // Per-tile step: TILE * trig / |other trig|
        S_OFF: begin
          if (div_done) begin
            cross0_r    <= POS_W'($signed({1'b0, other_p})) + quo_s;
            div_num_r   <= {trig_mag_r, {TILE_SHIFT{1'b0}}};
            div_start_r <= 1'b1;
            state_r     <= S_STEP;
          end
        end

        S_STEP: begin
          if (div_done) begin
            if (!dir_r) begin
              cx_r  <= cross0_r;
              cy_r  <= POS_W'(line0_r);
              stx_r <= quo_s;
              sty_r <= along_step;
            end else begin
              cx_r  <= POS_W'(line0_r);
              cy_r  <= cross0_r;
              stx_r <= along_step;
              sty_r <= quo_s;
            end
            n_r     <= '0;
            state_r <= S_CAST;
          end
        end

        // Walk the grid crossings, one cell test a cycle
        S_CAST: begin
          if (in_map && (cell_val != '0)) begin
            if (!dir_r) begin
              hh_r <= 1'b1;
              th_r <= cell_val;
              hx_r <= cx_r[COORD_W-1:0];
              hy_r <= cy_r[COORD_W-1:0];
            end else begin
              hv_r <= 1'b1;
              tv_r <= cell_val;
              vx_r <= cx_r[COORD_W-1:0];
              vy_r <= cy_r[COORD_W-1:0];
            end
          end else begin
            cx_r <= cx_r + stx_r;
            cy_r <= cy_r + sty_r;
            n_r  <= n_r + 1'b1;
          end
          if ((in_map && (cell_val != '0)) || last_cross) begin
            if (!dir_r) begin
              dir_r   <= 1'b1;
              state_r <= S_SETUP;
            end else begin
              dir_r   <= 1'b0;
              state_r <= S_SQX;
            end
          end
        end

        // Euclidean distance of each hit
        S_SQX: begin
          if (hit_sel) begin
            prod_r  <= dxx[31:0];
            state_r <= S_SQY;
          end else if (!dir_r) begin
            dir_r <= 1'b1;
          end else begin
            dir_r   <= 1'b0;
            state_r <= S_PICK;
          end
        end

        S_SQY: begin
          sq_in_r    <= SQ_IN_W'(prod_r) + SQ_IN_W'(dyy[31:0]);
          sq_start_r <= 1'b1;
          state_r    <= S_SQRT;
        end

        S_SQRT: begin
          if (sq_done) begin
            if (!dir_r) begin
              dh_r    <= sq_root;
              dir_r   <= 1'b1;
              state_r <= S_SQX;
            end else begin
              dv_r    <= sq_root;
              dir_r   <= 1'b0;
              state_r <= S_PICK;
            end
          end
        end

        // Nearer hit; horizontal wins ties
        S_PICK: begin
          side_r <= vert;
          type_r <= vert ? tv_r : th_r;
          rx_r   <= vert ? vx_r : hx_r;
          ry_r   <= vert ? vy_r : hy_r;
          dist_r <= vert ? dv_r : dh_r;
          if (!vert && !hh_r) begin
            dist16_r <= DIST_W'(DIST_MAX);
            state_r  <= S_HGT;
          end else begin
            cord_ang_r   <= view_r - ra_r;
            cord_start_r <= 1'b1;
            state_r      <= S_FISH;
          end
        end

        // Fisheye correction
        S_FISH: begin
          if (cord_done) begin
            corr_r  <= $signed({1'b0, dist_r}) * cord_cos;
            state_r <= S_SAT;
          end
        end

        S_SAT: begin
          if (corr_r[33] || (corr_r == '0)) dist16_r <= '0;
          else if (corr_r[33:32] != 2'b00) dist16_r <= DIST_W'(DIST_MAX);
          else dist16_r <= corr_r[31:16];
          state_r <= S_HGT;
        end

        // Slice height
        S_HGT: begin
          if (dist16_r == '0) begin
            height_r <= HGT_W'(HEIGHT_MAX);
            state_r  <= S_EMIT;
          end else begin
            div_num_r   <= DIV_NUM_W'(HEIGHT_NUM);
            div_den_r   <= dist16_r;
            div_start_r <= 1'b1;
            state_r     <= S_HDIV;
          end
        end

        S_HDIV: begin
          if (div_done) begin
            if (div_quo > DIV_NUM_W'(HEIGHT_MAX)) height_r <= HGT_W'(HEIGHT_MAX);
            else height_r <= div_quo[HGT_W-1:0];
            state_r <= S_EMIT;
          end
        end

        // Hand the ray to the result register once it is free
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            o_col_r     <= k_r;
            o_type_r    <= type_r;
            o_side_r    <= side_r;
            o_hx_r      <= rx_r;
            o_hy_r      <= ry_r;
            o_dist_r    <= dist16_r;
            o_hgt_r     <= height_r;
            o_top_r     <= HGT_W'(SCREEN_MID) - {1'b0, height_r[HGT_W-1:1]};
            o_last_r    <= k_r == COL_W'(RAY_COUNT-1);
            if (k_r == COL_W'(RAY_COUNT-1)) begin
              state_r <= S_IDLE;
            end else begin
              k_r          <= k_r + 1'b1;
              ra_r         <= ra_r + ANG_W'(ray_step_r);
              cord_ang_r   <= ra_r + ANG_W'(ray_step_r);
              cord_start_r <= 1'b1;
              state_r      <= S_TRIG;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  gwr_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start_r),
    .angle (cord_ang_r),
    .done  (cord_done),
    .cos_q (cord_cos),
    .sin_q (cord_sin)
  );

  gwr_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  gwr_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start_r),
    .value (sq_in_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign in_ready          = state_r == S_IDLE;
  assign out_valid         = out_valid_r;
  assign out_column        = o_col_r;
  assign out_wall_type     = o_type_r;
  assign out_vertical_side = o_side_r;
  assign out_hit_x         = $signed({2'b00, o_hx_r});
  assign out_hit_y         = $signed({2'b00, o_hy_r});
  assign out_wall_distance = o_dist_r;
  assign out_slice_height  = o_hgt_r;
  assign out_slice_top     = $signed(o_top_r);
  assign out_last_ray      = o_last_r;

endmodule

// ----- hdl/gwr_checker.sv -----
module gwr_assert_chk
  import gwr_pkg::*;
#(
  parameter int RAY_COUNT = 60
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [COORD_W-1:0]      in_viewer_x,
  input logic [COORD_W-1:0]      in_viewer_y,
  input logic [ANG_W-1:0]        in_view_angle,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [COL_W-1:0]        out_column,
  input logic [TYPE_W-1:0]       out_wall_type,
  input logic                    out_vertical_side,
  input logic signed [HIT_W-1:0] out_hit_x,
  input logic signed [HIT_W-1:0] out_hit_y,
  input logic [DIST_W-1:0]       out_wall_distance,
  input logic [HGT_W-1:0]        out_slice_height,
  input logic signed [HGT_W-1:0] out_slice_top,
  input logic                    out_last_ray,
  input logic                    cfg_we,
  input logic [CFG_IDX_W-1:0]    cfg_index,
  input logic [CFG_DATA_W-1:0]   cfg_data
);

  // A frame beat makes the block busy
  a_busy_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after a frame beat");

  // Stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_column)
      && $stable(out_wall_distance))
    else $error("stalled result changed");

  // Last ray carries the last column
  a_last_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_ray |-> out_column == COL_W'(RAY_COUNT-1))
    else $error("last ray flag on wrong column");

  // Slice top follows the height
  a_slice_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_slice_top ==
      $signed(HGT_W'(SCREEN_MID) - {1'b0, out_slice_height[HGT_W-1:1]}))
    else $error("slice top inconsistent with height");

  // No wall means saturated distance
  a_miss_distance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_wall_type == '0) |-> out_wall_distance == DIST_W'(DIST_MAX))
    else $error("miss without saturated distance");

endmodule

bind grid_wall_raycaster_core gwr_assert_chk #(.RAY_COUNT(RAY_COUNT)) u_gwr_checker (.*);

// ----- dv/gwr_checker.sv -----
`timescale 1ns / 1ps

module gwr_checker
  import gwr_pkg::*;
#(
  parameter int RAY_COUNT     = 60,
  parameter int MAX_CROSSINGS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [COORD_W-1:0]      in_viewer_x,
  input  logic [COORD_W-1:0]      in_viewer_y,
  input  logic [ANG_W-1:0]        in_view_angle,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [COL_W-1:0]        out_column,
  input  logic [TYPE_W-1:0]       out_wall_type,
  input  logic                    out_vertical_side,
  input  logic signed [HIT_W-1:0] out_hit_x,
  input  logic signed [HIT_W-1:0] out_hit_y,
  input  logic [DIST_W-1:0]       out_wall_distance,
  input  logic [HGT_W-1:0]        out_slice_height,
  input  logic signed [HGT_W-1:0] out_slice_top,
  input  logic                    out_last_ray,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [TYPE_W-1:0] wall_type;
    logic              vertical_side;
    logic [HIT_W-1:0]  hit_x;
    logic [HIT_W-1:0]  hit_y;
    logic [DIST_W-1:0] wall_distance;
    logic [HGT_W-1:0]  slice_height;
    logic [HGT_W-1:0]  slice_top;
    logic              last_ray;
  } ray_beat_t;

  // Shadow copy of the register file
  logic [63:0]       map_lo, map_hi;
  logic [STEP_W-1:0] step_reg;
  logic [OFF_W-1:0]  off_reg;

  int err_cnt = 0;

  ray_beat_t wall_q[$];

  assign pending = wall_q.size();
  assign errors  = err_cnt;

  // Rotation of a unit vector, Q1.14 cos/sin with quadrant folding
  task automatic rotate(input logic [15:0] ang, output longint c, output longint s);
    longint x, y, z, xs, ys, cm, sm;
    x = CORDIC_GAIN_Q20;
    y = 0;
    z = longint'(ang[13:0]) * 256;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(atan_unit(i[3:0]));
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(atan_unit(i[3:0]));
      end
    end
    cm = (x + 32) >>> 6;
    sm = (y + 32) >>> 6;
    if (cm < 0) cm = 0;
    if (cm > ONE_Q14) cm = ONE_Q14;
    if (sm < 0) sm = 0;
    if (sm > ONE_Q14) sm = ONE_Q14;
    case (ang[15:14])
      2'd0: begin c = cm;  s = sm;  end
      2'd1: begin c = -sm; s = cm;  end
      2'd2: begin c = -cm; s = -sm; end
      default: begin c = sm; s = -cm; end
    endcase
  endtask

  function automatic logic [1:0] map_cell(longint x, longint y);
    int idx;
    logic [63:0] r;
    if (x < 0 || y < 0 || x >= 8 * TILE_Q || y >= 8 * TILE_Q) return 2'd0;
    idx = int'(y / TILE_Q) * 8 + int'(x / TILE_Q);
    r = (idx < 32) ? map_lo : map_hi;
    return r[2 * (idx % 32) +: 2];
  endfunction

  // Walk MAX_CROSSINGS grid crossings and keep the first wall cell found
  task automatic walk(input longint x0, input longint y0, input longint xo,
                      input longint yo, output bit hit, output logic [1:0] t,
                      output longint hx, output longint hy);
    longint x, y;
    x = x0;
    y = y0;
    hit = 0;
    t = 0;
    hx = 0;
    hy = 0;
    for (int n = 0; n < MAX_CROSSINGS; n++) begin
      if (!hit && map_cell(x, y) != 0) begin
        hit = 1; t = map_cell(x, y); hx = x; hy = y;
      end
      x = x + xo;
      y = y + yo;
    end
  endtask

  function automatic longint root_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // Expected ray beats of one frame request
  task automatic cast_frame(input logic [15:0] vx_in, input logic [15:0] vy_in,
                            input logic [15:0] view);
    longint px, py, gx, gy, c, s, fc, fs, a, y0, x0, d0, xo, yo;
    longint hx, hy, vx, vy, rx, ry, dh, dv, ray_dist, corr, height;
    logic [15:0] ra;
    logic [1:0] th, tv;
    bit hh, hv, vert, left;
    ray_beat_t b;
    px = vx_in;
    py = vy_in;
    gx = (px / TILE_Q) * TILE_Q;
    gy = (py / TILE_Q) * TILE_Q;
    ra = view - 16'(32'(off_reg) * 32'(step_reg));
    for (int k = 0; k < RAY_COUNT; k++) begin
      rotate(ra, c, s);
      hh = 0; hv = 0; th = 0; tv = 0;
      hx = px; hy = py; vx = px; vy = py;
      dh = 0; dv = 0;
      if (ra != ANG_ZERO && ra != ANG_HALF && s != 0) begin
        a = (s < 0) ? -s : s;
        y0 = (ra < ANG_HALF) ? gy + TILE_Q : gy - 1;
        d0 = (y0 > py) ? y0 - py : py - y0;
        x0 = px + (d0 * c) / a;
        xo = (longint'(TILE_Q) * c) / a;
        yo = (ra < ANG_HALF) ? TILE_Q : -TILE_Q;
        walk(x0, y0, xo, yo, hh, th, hx, hy);
        if (!hh) begin hx = px; hy = py; end
      end
      if (ra != ANG_QUARTER && ra != ANG_3QUART && c != 0) begin
        a = (c < 0) ? -c : c;
        left = (ra > ANG_QUARTER) && (ra < ANG_3QUART);
        x0 = left ? gx - 1 : gx + TILE_Q;
        d0 = (x0 > px) ? x0 - px : px - x0;
        y0 = py + (d0 * s) / a;
        yo = (longint'(TILE_Q) * s) / a;
        xo = left ? -TILE_Q : TILE_Q;
        walk(x0, y0, xo, yo, hv, tv, vx, vy);
      end
      if (hh) dh = root_floor((hx - px) * (hx - px) + (hy - py) * (hy - py));
      if (hv) dv = root_floor((vx - px) * (vx - px) + (vy - py) * (vy - py));
      vert = hv && (!hh || dv < dh);
      if (vert) begin b.wall_type = tv; rx = vx; ry = vy; ray_dist = dv; end
      else begin b.wall_type = th; rx = hx; ry = hy; ray_dist = dh; end
      if (!vert && !hh) ray_dist = DIST_MAX;
      else begin
        rotate(view - ra, fc, fs);
        corr = ray_dist * fc;
        if (corr <= 0) ray_dist = 0;
        else begin
          ray_dist = corr >>> 16;
          if (ray_dist > DIST_MAX) ray_dist = DIST_MAX;
        end
      end
      if (ray_dist == 0) height = HEIGHT_MAX;
      else begin
        height = HEIGHT_NUM / ray_dist;
        if (height > HEIGHT_MAX) height = HEIGHT_MAX;
      end
      b.column        = COL_W'(k);
      b.vertical_side = vert;
      b.hit_x         = HIT_W'(rx);
      b.hit_y         = HIT_W'(ry);
      b.wall_distance = DIST_W'(ray_dist);
      b.slice_height  = HGT_W'(height);
      b.slice_top     = HGT_W'(SCREEN_MID - height / 2);
      b.last_ray      = (k == RAY_COUNT - 1);
      wall_q.push_back(b);
      ra = ra + 16'(step_reg);
    end
  endtask

  // Register shadow, frame prediction and ray comparison
  always @(posedge clk) begin
    ray_beat_t want, got;
    if (!rst_n) begin
      map_lo   <= '0;
      map_hi   <= '0;
      step_reg <= STEP_W'(182);
      off_reg  <= OFF_W'(30);
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MAP_LO:    map_lo   <= cfg_data;
          CFG_MAP_HI:    map_hi   <= cfg_data;
          CFG_RAY_STEP:  step_reg <= cfg_data[STEP_W-1:0];
          CFG_START_OFF: off_reg  <= cfg_data[OFF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) cast_frame(in_viewer_x, in_viewer_y, in_view_angle);
      if (out_valid && out_ready) begin
        got = '{out_column, out_wall_type, out_vertical_side, out_hit_x, out_hit_y,
                out_wall_distance, out_slice_height, out_slice_top, out_last_ray};
        if (wall_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected ray beat: %p", got);
        end else begin
          want = wall_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10) $display("ray mismatch\n  exp %p\n  got %p", want, got);
          end
        end
      end
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import gwr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                    clk = 0;
  logic                    rst_n = 0;
  logic                    in_valid = 0;
  logic                    in_ready;
  logic [COORD_W-1:0]      in_viewer_x = 0;
  logic [COORD_W-1:0]      in_viewer_y = 0;
  logic [ANG_W-1:0]        in_view_angle = 0;
  logic                    out_valid;
  logic                    out_ready = 0;
  logic [COL_W-1:0]        out_column;
  logic [TYPE_W-1:0]       out_wall_type;
  logic                    out_vertical_side;
  logic signed [HIT_W-1:0] out_hit_x, out_hit_y;
  logic [DIST_W-1:0]       out_wall_distance;
  logic [HGT_W-1:0]        out_slice_height;
  logic signed [HGT_W-1:0] out_slice_top;
  logic                    out_last_ray;
  logic                    cfg_we = 0;
  logic [CFG_IDX_W-1:0]    cfg_index = 0;
  logic [CFG_DATA_W-1:0]   cfg_data = 0;

  int  errors, pending;
  bit  calm = 0;          // no idling on either side
  bit  hold_req = 0;      // receiver long hold-off request
  int  stall_cycles = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  grid_wall_raycaster_core dut (.*);

  gwr_checker chk (.*);

  // Result side: random ready gaps, one long hold-off on request
  initial begin
    int w;
    forever begin
      if (hold_req) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_req = 0;
      end else begin
        w = calm ? 0 : $urandom_range(0, 4);
        if (w > 0) begin
          out_ready <= 0;
          repeat (w) @(posedge clk);
        end
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_frame(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] ang);
    int w;
    w = calm ? 0 : $urandom_range(0, 4);
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_valid      <= 1;
    in_viewer_x   <= x;
    in_viewer_y   <= y;
    in_view_angle <= ang;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [63:0] lo, input logic [63:0] hi,
                           input int unsigned rstep, input int unsigned roff);
    cfg_we <= 1; cfg_index <= CFG_MAP_LO;    cfg_data <= lo;    @(posedge clk);
    cfg_index <= CFG_MAP_HI;    cfg_data <= hi;                 @(posedge clk);
    cfg_index <= CFG_RAY_STEP;  cfg_data <= 64'(rstep);         @(posedge clk);
    cfg_index <= CFG_START_OFF; cfg_data <= 64'(roff);          @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Map with the given wall density in percent
  function automatic logic [63:0] rand_map(int pct);
    logic [63:0] m;
    for (int i = 0; i < 32; i++)
      m[2*i +: 2] = ($urandom_range(0, 99) < pct) ? 2'($urandom_range(1, 3)) : 2'd0;
    return m;
  endfunction

  function automatic logic [15:0] rand_angle;
    case ($urandom_range(0, 7))
      0: return ANG_ZERO;
      1: return ANG_QUARTER;
      2: return ANG_HALF;
      3: return ANG_3QUART;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned rstep, roff;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset defaults: empty map, nothing is hit
    send_frame(16'd0, 16'd0, ANG_ZERO);
    send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    // Side walls with two full middle rows, axis angles and corner positions
    write_cfg(64'hFFFF_C003_C003_C003, 64'hC003_C003_C003_FFFF, 182, 30);
    send_frame(16'h8000, 16'h8000, ANG_ZERO);
    send_frame(16'h8000, 16'h8000, ANG_QUARTER);
    send_frame(16'h8000, 16'h8000, ANG_HALF);
    send_frame(16'h8000, 16'h8000, ANG_3QUART);
    send_frame(16'h2000, 16'h2000, 16'h2000);
    send_frame(16'hFFFF, 16'h0000, 16'hA000);
    send_frame(16'h0000, 16'hFFFF, 16'hE000);
    drain();

    // Every cell a wall, zero step, no offset
    write_cfg('1, '1, 0, 0);
    send_frame(16'h1234, 16'h5678, 16'h4000);
    send_frame(16'hFFFF, 16'hFFFF, 16'h0000);
    drain();

    // Widest fan: negative cosine correction
    write_cfg(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 4095, 63);
    send_frame(16'h5555, 16'hAAAA, 16'h1111);
    send_frame(16'hAAAA, 16'h5555, 16'hEEEE);
    send_frame(16'h0001, 16'hFFFE, 16'h8000);
    drain();

    write_cfg(rand_map(30), rand_map(30), 1, 63);
    send_frame(16'h4321, 16'h7777, 16'h0001);
    send_frame(16'hC000, 16'h3FFF, 16'hFFFF);
    drain();

    // Random phases
    for (int p = 0; p < 9; p++) begin
      case (p % 4)
        0: begin rstep = 182; roff = 30; end
        1: begin rstep = $urandom_range(1, 4095); roff = $urandom_range(0, 63); end
        2: begin rstep = $urandom_range(1, 400); roff = $urandom_range(0, 63); end
        default: begin rstep = $urandom_range(0, 4095); roff = $urandom_range(0, 63); end
      endcase
      write_cfg(rand_map($urandom_range(5, 60)), rand_map($urandom_range(5, 60)),
                rstep, roff);
      calm = (p == 2);
      for (int n = 0; n < 30; n++) begin
        if (p == 4 && n == 10) hold_req = 1;
        if (p == 6 && n == 15) begin
          in_valid <= 0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_frame(16'($urandom), 16'($urandom), rand_angle());
      end
      drain();
    end

    repeat (300) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
